[hw/rtl/tle_pkg.sv]
package tle_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIFF_BITS;
   localparam int ROOT_BITS  = SQ_BITS / 2;

   // result widths
   localparam int COST_BITS  = 27;
   localparam int EDGE_BITS  = 11;

   // edge counter limit
   localparam int MAX_POINTS = 1024;
   localparam int EDGE_LIMIT = (MAX_POINTS < 2047) ? MAX_POINTS : 2047;

endpackage

[hw/rtl/tle_req_if.sv]
interface tle_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tle_pkg::COORD_BITS-1:0]  point_x;
   logic signed [tle_pkg::COORD_BITS-1:0]  point_y;
   logic                                   last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

[hw/rtl/tle_rsp_if.sv]
interface tle_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tle_pkg::COST_BITS-1:0]   tour_cost;
   logic [tle_pkg::EDGE_BITS-1:0]   edge_count;

   modport source (output valid, tour_cost, edge_count, input ready);
   modport sink (input valid, tour_cost, edge_count, output ready);
endinterface

[hw/rtl/tle_isqrt.sv]
module tle_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tle_pkg::SQ_BITS-1:0]    radicand,
   output logic                           done,
   output logic [tle_pkg::ROOT_BITS-1:0]  root
);

   localparam int REM_BITS = tle_pkg::ROOT_BITS + 3;
   localparam int CNT_BITS = $clog2(tle_pkg::ROOT_BITS);

   logic [tle_pkg::SQ_BITS-1:0]    rad_ff, rad_in;
   logic [REM_BITS-1:0]            rem_ff, rem_in;
   logic [tle_pkg::ROOT_BITS-1:0]  root_ff, root_in;
   logic [CNT_BITS-1:0]            count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [REM_BITS-1:0]            shifted;
   logic [REM_BITS:0]              trial;

   // one root bit per step: bring down the next bit pair and try a subtract
   always_comb begin
      shifted = {rem_ff[REM_BITS-3:0], rad_ff[tle_pkg::SQ_BITS-1 -: 2]};
      trial   = {1'b0, shifted} - {2'b00, root_ff, 2'b01};
   end

   always_comb begin
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rad_in   = {rad_ff[tle_pkg::SQ_BITS-3:0], 2'b00};
         count_in = count_ff + CNT_BITS'(1);
         if (!trial[REM_BITS]) begin
            rem_in  = trial[REM_BITS-1:0];
            root_in = {root_ff[tle_pkg::ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[tle_pkg::ROOT_BITS-2:0], 1'b0};
         end
         if (count_ff == CNT_BITS'(tle_pkg::ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hw/rtl/tour_length_evaluator.sv]
// Euclidean tour length, fixed point.
// req_chan carries the points of a closed tour in visiting order, one per
// transaction; the closing copy of the first point comes last with
// last_point set. rsp_chan carries one transaction per tour: tour_cost, the
// saturating sum of floor edge lengths, and edge_count, the edges summed (held at 1024).
// The first point of a tour only loads the previous-point register. Every
// later point takes the differences on acceptance, squares them in turn on
// the shared 17x17 squarer (SQUARE_X, SQUARE_Y), launches the root in
// START_ROOT, waits in WAIT_ROOT through the 17 steps of the bit-pair
// square root unit and accumulates in ACCUM. The root unit sets the rate.
// req_chan.ready is high only while idle.
// The result sits in an output register, so points of the next tour are
// taken while it waits; only a second finished tour waits for rsp_chan.ready.
// Reset clears the running sum, edge counter, previous-point flag and the
// pending result; a marked point with no previous point reports zero.
module tour_length_evaluator (
   input  logic     clock,
   input  logic     reset,
   tle_req_if.sink  req_chan,
   tle_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      IDLE,
      SQUARE_X,
      SQUARE_Y,
      START_ROOT,
      WAIT_ROOT,
      ACCUM,
      FINISH
   } state_type;

   localparam int DB = tle_pkg::DIFF_BITS;

   state_type                        state_ff, state_in;
   logic signed [tle_pkg::COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic signed [tle_pkg::COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic                             have_prev_ff, have_prev_in;
   logic                             last_ff, last_in;
   logic [DB-1:0]                    dx_ff, dx_in;
   logic [DB-1:0]                    dy_ff, dy_in;
   logic [tle_pkg::SQ_BITS-1:0]      sumsq_ff, sumsq_in;
   logic [tle_pkg::COST_BITS-1:0]    cost_ff, cost_in;
   logic [tle_pkg::EDGE_BITS-1:0]    edges_ff, edges_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tle_pkg::COST_BITS-1:0]    rsp_cost_ff, rsp_cost_in;
   logic [tle_pkg::EDGE_BITS-1:0]    rsp_edges_ff, rsp_edges_in;

   logic                             accept;
   logic signed [DB:0]               diff_x, diff_y;
   logic [DB-1:0]                    sq_op;
   logic [tle_pkg::SQ_BITS-1:0]      prod;
   logic                             root_start;
   logic                             root_done;
   logic [tle_pkg::ROOT_BITS-1:0]    root;
   logic [tle_pkg::COST_BITS:0]      cost_sum;

   assign accept = req_chan.valid && (state_ff == IDLE);

   // signed differences to the previous point
   always_comb begin
      diff_x = (DB+1)'(req_chan.point_x) - (DB+1)'(prev_x_ff);
      diff_y = (DB+1)'(req_chan.point_y) - (DB+1)'(prev_y_ff);
   end

   // shared squarer
   assign sq_op = (state_ff == SQUARE_X) ? dx_ff : dy_ff;
   assign prod  = sq_op * sq_op;

   assign root_start = (state_ff == START_ROOT);

   tle_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sumsq_ff),
      .done     (root_done),
      .root     (root)
   );

   // running sum with headroom for saturation
   assign cost_sum = {1'b0, cost_ff} + (tle_pkg::COST_BITS+1)'(root);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      last_in      = last_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sumsq_in     = sumsq_ff;
      cost_in      = cost_ff;
      edges_in     = edges_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_edges_in = rsp_edges_ff;

      // result register drains independently
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (accept) begin
               prev_x_in    = req_chan.point_x;
               prev_y_in    = req_chan.point_y;
               have_prev_in = 1'b1;
               last_in      = req_chan.last_point;
               dx_in = diff_x[DB] ? DB'(-diff_x) : diff_x[DB-1:0];
               dy_in = diff_y[DB] ? DB'(-diff_y) : diff_y[DB-1:0];
               if (have_prev_ff) begin
                  state_in = SQUARE_X;
               end else if (req_chan.last_point) begin
                  state_in = FINISH;
               end
            end
         end
         SQUARE_X: begin
            sumsq_in = prod;
            state_in = SQUARE_Y;
         end
         SQUARE_Y: begin
            sumsq_in = sumsq_ff + prod;
            state_in = START_ROOT;
         end
         START_ROOT: begin
            state_in = WAIT_ROOT;
         end
         WAIT_ROOT: begin
            if (root_done) begin
               state_in = ACCUM;
            end
         end
         ACCUM: begin
            cost_in = cost_sum[tle_pkg::COST_BITS] ? '1
                                                   : cost_sum[tle_pkg::COST_BITS-1:0];
            if (edges_ff < tle_pkg::EDGE_BITS'(tle_pkg::EDGE_LIMIT)) begin
               edges_in = edges_ff + tle_pkg::EDGE_BITS'(1);
            end
            state_in = last_ff ? FINISH : IDLE;
         end
         FINISH: begin
            // hand the total to the output register and start a new tour
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = cost_ff;
               rsp_edges_in = edges_ff;
               cost_in      = '0;
               edges_in     = '0;
               have_prev_in = 1'b0;
               prev_x_in    = '0;
               prev_y_in    = '0;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         cost_ff      <= '0;
         edges_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         cost_ff      <= cost_in;
         edges_ff     <= edges_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff      <= last_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sumsq_ff     <= sumsq_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_edges_ff <= rsp_edges_in;
   end

   assign req_chan.ready      = (state_ff == IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.tour_cost  = rsp_cost_ff;
   assign rsp_chan.edge_count = rsp_edges_ff;

endmodule
